FILE: design/utf16_to_utf8_transcoder_defines.svh
// assertion macros shared by the transcoder modules
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define U2U8_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define U2U8_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/u2u8_pkg.sv
`default_nettype none
package u2u8_pkg;

  // surrogate tags in bits 15:10 of a code unit
  localparam logic [5:0] U2U8_HIGH_TAG = 6'b110110;
  localparam logic [5:0] U2U8_LOW_TAG  = 6'b110111;

  localparam int unsigned U2U8_CP_W = 21;
  localparam logic [U2U8_CP_W-1:0] U2U8_SUPP_BASE = 21'h10000;
  localparam logic [U2U8_CP_W-1:0] U2U8_REPL_CP   = 21'h0FFFD;

  // default number of queued tasks between front and back
  localparam int unsigned U2U8_QUEUE_DEPTH = 2;

  // one unit of work for the back end
  typedef struct packed {
    logic                 pre_fffd; // replacement for a dropped high surrogate first
    logic                 emit;     // code point below follows
    logic [U2U8_CP_W-1:0] cp;
    logic                 last;     // final byte of cp closes the name
  } u2u8_task_t;

  // index of the final utf-8 byte of a code point (length minus one)
  function automatic logic [1:0] u2u8_last_idx(input logic [U2U8_CP_W-1:0] cp);
    logic [1:0] r;
    if (cp[20:7] == '0) begin
      r = 2'd0;
    end else if (cp[20:11] == '0) begin
      r = 2'd1;
    end else if (cp[20:16] == '0) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // utf-8 byte number idx of a code point whose final index is last_idx
  function automatic logic [7:0] u2u8_byte(input logic [U2U8_CP_W-1:0] cp,
                                           input logic [1:0] last_idx,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (last_idx)
      2'd0: begin
        b = cp[7:0];
      end
      2'd1: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: design/u2u8_front.sv
`default_nettype none
module u2u8_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [15:0]          code_unit,
  input  wire logic                 end_of_name,
  output      logic                 push,
  output      u2u8_pkg::u2u8_task_t task_out
);
  import u2u8_pkg::*;

  `include "utf16_to_utf8_transcoder_defines.svh"

  logic       held_valid_r, held_valid_nxt;
  logic [9:0] held_bits_r, held_bits_nxt;
  logic       accept, is_high, is_low;

  assign accept  = in_valid && in_ready;
  assign is_high = (code_unit[15:10] == U2U8_HIGH_TAG);
  assign is_low  = (code_unit[15:10] == U2U8_LOW_TAG);

  // classify the unit into a task
  always_comb begin
    task_out.pre_fffd = 1'b0;
    task_out.emit     = 1'b1;
    task_out.cp       = {{(U2U8_CP_W-16){1'b0}}, code_unit};
    task_out.last     = end_of_name;
    if (held_valid_r && is_low) begin
      task_out.cp = U2U8_SUPP_BASE + {1'b0, held_bits_r, code_unit[9:0]};
    end else begin
      task_out.pre_fffd = held_valid_r;
      if (is_high) begin
        task_out.emit = end_of_name;
        task_out.cp   = U2U8_REPL_CP;
      end else if (is_low) begin
        task_out.cp = U2U8_REPL_CP;
      end
    end
  end

  assign push = accept && (task_out.pre_fffd || task_out.emit);

  // hold a high surrogate until its partner arrives
  always_comb begin
    held_valid_nxt = held_valid_r;
    held_bits_nxt  = held_bits_r;
    if (accept) begin
      held_valid_nxt = is_high && !end_of_name;
      held_bits_nxt  = is_high ? code_unit[9:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_bits_r  <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_bits_r  <= held_bits_nxt;
    end
  end

  `U2U8_ASSERT_NEXT(a_pair_clears_hold, clk, rst_n, accept && held_valid_r && is_low, !held_valid_r, "surrogate pair left a high surrogate held")

endmodule
`default_nettype wire

FILE: design/u2u8_fifo.sv
`default_nettype none
module u2u8_fifo #(
  parameter int unsigned DEPTH = u2u8_pkg::U2U8_QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire u2u8_pkg::u2u8_task_t push_task,
  input  wire logic                 pop,
  output      u2u8_pkg::u2u8_task_t head_task,
  output      logic                 head_valid,
  output      logic                 full
);
  import u2u8_pkg::*;

  `include "utf16_to_utf8_transcoder_defines.svh"

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u2u8_task_t    slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign head_task  = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == FULL_CNT);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_task;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  `U2U8_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full || pop, "task pushed into a full queue")
  `U2U8_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, head_valid, "task popped from an empty queue")

endmodule
`default_nettype wire

FILE: design/u2u8_back.sv
`default_nettype none
module u2u8_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire u2u8_pkg::u2u8_task_t head_task,
  input  wire logic                 head_valid,
  output      logic                 pop,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [7:0]           utf8_byte,
  output      logic                 last_byte
);
  import u2u8_pkg::*;

  `include "utf16_to_utf8_transcoder_defines.svh"

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       pre_done_r, pre_done_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic       load, sel_pre, seg_end;
  logic [1:0] cp_last_idx, seg_last_idx;
  logic [7:0] byte_nxt;
  logic       last_nxt;

  // pick the segment: replacement prefix or the code point itself
  assign sel_pre      = head_task.pre_fffd && !pre_done_r;
  assign cp_last_idx  = u2u8_last_idx(head_task.cp);
  assign seg_last_idx = sel_pre ? 2'd2 : cp_last_idx;
  assign seg_end      = (idx_r == seg_last_idx);
  assign byte_nxt     = sel_pre ? u2u8_byte(U2U8_REPL_CP, 2'd2, idx_r)
                                : u2u8_byte(head_task.cp, cp_last_idx, idx_r);
  assign last_nxt     = !sel_pre && head_task.last && seg_end;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && seg_end && !(sel_pre && head_task.emit);

  // byte position within the task
  always_comb begin
    idx_nxt      = idx_r;
    pre_done_nxt = pre_done_r;
    if (load) begin
      if (pop) begin
        idx_nxt      = 2'd0;
        pre_done_nxt = 1'b0;
      end else if (seg_end) begin
        idx_nxt      = 2'd0;
        pre_done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      pre_done_r  <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      pre_done_r <= pre_done_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign utf8_byte = byte_r;
  assign last_byte = last_r;

  `U2U8_ASSERT_NEXT(a_pop_restarts, clk, rst_n, pop, idx_r == 2'd0 && !pre_done_r, "task pop left byte position behind")

endmodule
`default_nettype wire

FILE: design/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. Each input request carries one UTF-16 code unit
// (in_tdata[15:0]) with in_tlast on the last unit of a name; each output request
// carries one UTF-8 byte with out_tlast on the final byte of the name. A high
// surrogate is held until the next unit; a valid pair gives four bytes, while a
// broken or lone surrogate gives U+FFFD (EF BF BD). A front stage classifies each
// unit in the cycle it is accepted and queues a task; the back end sends one byte
// per cycle from a registered output while the receiver is ready and a task is
// queued. A unit gives 1 to 3 bytes (ASCII 1, up to U+07FF 2, rest of the BMP 3),
// a surrogate pair 4 bytes in total, and a unit after a broken high surrogate 3
// more. A held high surrogate gives no output byte. The task queue lets the input
// run ahead of the output by QUEUE_DEPTH tasks.
`default_nettype none
module utf16_to_utf8_transcoder #(
  parameter int unsigned QUEUE_DEPTH = u2u8_pkg::U2U8_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,  // [15:0] code_unit
  input  wire logic        in_tlast,  // end_of_name
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [7:0]  out_tdata, // [7:0] utf8_byte
  output      logic        out_tlast  // last_byte
);
  import u2u8_pkg::*;

  u2u8_task_t push_task, head_task;
  logic       push, pop, head_valid, q_full;

  assign in_tready = !q_full;

  // classify units, track held high surrogate
  u2u8_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .code_unit   (in_tdata),
    .end_of_name (in_tlast),
    .push        (push),
    .task_out    (push_task)
  );

  // task queue between front and back
  u2u8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_task  (push_task),
    .pop        (pop),
    .head_task  (head_task),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // byte serialiser with output register
  u2u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_task  (head_task),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .utf8_byte  (out_tdata),
    .last_byte  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u2u8_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int NUM_DIRECTED = 24;
  localparam int NUM_PHASES   = 6;

  // kinds of random unit sequence
  typedef enum int {
    SEQ_ASCII, SEQ_TWO_BYTE, SEQ_THREE_BYTE, SEQ_PAIR,
    SEQ_BROKEN_HIGH, SEQ_LONE_LOW, SEQ_ZERO, SEQ_RAW
  } seq_kind_t;

  // one utf-8 byte as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_res_t;

  // stimulus row; bytes and lasts hold the first byte in the top bits
  typedef struct packed {
    logic [15:0] code_unit;
    logic        eon;
    logic        typed;
    logic [2:0]  n;
    logic [47:0] bytes;
    logic [5:0]  lasts;
  } dir_row_t;

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{16'h0000, 1'b1, 1'b1, 3'd1, 48'h00_0000000000, 6'b100000},
    '{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_0000000000, 6'b000000},
    '{16'h0080, 1'b0, 1'b0, 3'd0, 48'h0, 6'b0},
    '{16'h07FF, 1'b0, 1'b0, 3'd0, 48'h0, 6'b0},
    '{16'h0800, 1'b0, 1'b0, 3'd0, 48'h0, 6'b0},
    '{16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEFBFBF_000000, 6'b001000},
    // smallest pair, U+10000
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0, 6'b0},
    '{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0908080_0000, 6'b000000},
    // largest pair, U+10FFFF
    '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0, 6'b0},
    '{16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF48FBFBF_0000, 6'b000100},
    // lone low surrogate closing a name
    '{16'hDC00, 1'b1, 1'b1, 3'd3, 48'hEFBFBD_000000, 6'b001000},
    // high surrogate on the last unit
    '{16'hD800, 1'b1, 1'b1, 3'd3, 48'hEFBFBD_000000, 6'b001000},
    // held high broken by plain ascii
    '{16'hDABC, 1'b0, 1'b1, 3'd0, 48'h0, 6'b0},
    '{16'h0041, 1'b1, 1'b1, 3'd4, 48'hEFBFBD41_0000, 6'b000100},
    // high after high, then a high closing the name: six bytes
    '{16'hD801, 1'b0, 1'b1, 3'd0, 48'h0, 6'b0},
    '{16'hD802, 1'b0, 1'b1, 3'd3, 48'hEFBFBD_000000, 6'b000000},
    '{16'hDBFF, 1'b1, 1'b1, 3'd6, 48'hEFBFBDEFBFBD, 6'b000001},
    // held high broken by a three-byte unit
    '{16'hD900, 1'b0, 1'b1, 3'd0, 48'h0, 6'b0},
    '{16'hE000, 1'b0, 1'b0, 3'd0, 48'h0, 6'b0},
    '{16'hD83D, 1'b0, 1'b1, 3'd0, 48'h0, 6'b0},
    '{16'hDE00, 1'b1, 1'b0, 3'd0, 48'h0, 6'b0},
    // lone low surrogate inside a name
    '{16'hDFFF, 1'b0, 1'b1, 3'd3, 48'hEFBFBD_000000, 6'b000000},
    '{16'h5555, 1'b0, 1'b0, 3'd0, 48'h0, 6'b0},
    '{16'hAAAA, 1'b1, 1'b0, 3'd0, 48'h0, 6'b0}
  };

  // per phase: sender idle %, receiver stall %, running unit count to reach
  localparam int PHASE_SEND [NUM_PHASES] = '{0, 0, 76, 0, 33, 0};
  localparam int PHASE_RECV [NUM_PHASES] = '{0, 0, 0, 76, 33, 0};
  localparam int PHASE_END  [NUM_PHASES] = '{30, 95, 160, 225, 290, 346};

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata  = '0;
  logic        in_tlast  = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        hold_req       = 1'b0;
  int          hold_left      = 0;
  int          units_sent     = 0;
  int          err_cnt        = 0;
  int          cycle_cnt      = 0;

  // predictor state: the surrogate being held
  logic [9:0]  hs_bits    = '0;
  logic        hs_pending = 1'b0;

  utf8_res_t   step_out  [$];
  utf8_res_t   utf8_fifo [$];

  utf16_to_utf8_transcoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // utf-8 bytes of one code point
  function automatic void encode_cp(input logic [20:0] cp, input logic mark);
    logic [7:0] b [4];
    int len;
    if (cp < 21'h80) begin
      b[0] = cp[7:0];
      len = 1;
    end else if (cp < 21'h800) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
      len = 2;
    end else if (cp < 21'h10000) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
      len = 3;
    end else begin
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
      len = 4;
    end
    for (int i = 0; i < len; i++) begin
      step_out.push_back('{b[i], mark && (i == len - 1)});
    end
  endfunction

  // bytes caused by one accepted code unit, into step_out
  function automatic void transcode_unit(input logic [15:0] cu, input logic eon);
    logic is_high;
    logic is_low;
    logic paired;
    is_high = (cu[15:10] == U2U8_HIGH_TAG);
    is_low  = (cu[15:10] == U2U8_LOW_TAG);
    paired  = hs_pending && is_low;
    step_out.delete();
    if (paired) begin
      encode_cp(U2U8_SUPP_BASE + {1'b0, hs_bits, cu[9:0]}, eon);
    end else begin
      // a held high that is not completed becomes a replacement first
      if (hs_pending) begin
        encode_cp(U2U8_REPL_CP, 1'b0);
      end
      if (is_high && !eon) begin
        hs_bits = cu[9:0];
        hs_pending = 1'b1;
      end else if (is_high || is_low) begin
        encode_cp(U2U8_REPL_CP, eon);
      end else begin
        encode_cp({5'b0, cu}, eon);
      end
    end
    if (paired || !is_high || eon) begin
      hs_pending = 1'b0;
      hs_bits = '0;
    end
  endfunction

  // offer one unit, wait for its request to be taken, queue its bytes
  task automatic send_unit(input dir_row_t row);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row.code_unit;
    in_tlast  <= row.eon;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    transcode_unit(row.code_unit, row.eon);
    if (row.typed) begin
      for (int i = 0; i < row.n; i++) begin
        utf8_fifo.push_back('{row.bytes[47 - 8 * i -: 8], row.lasts[5 - i]});
      end
    end else begin
      foreach (step_out[i]) utf8_fifo.push_back(step_out[i]);
    end
    units_sent++;
  endtask

  task automatic send_plain(input logic [15:0] cu, input logic eon);
    send_unit('{cu, eon, 1'b0, 3'd0, 48'd0, 6'd0});
  endtask

  // one random sequence, mostly well-formed text
  task automatic send_random();
    int r;
    seq_kind_t kind;
    logic [15:0] cu;
    logic eon;
    r = $urandom_range(0, 99);
    eon = ($urandom_range(0, 5) == 0);
    if (r < 15)      kind = SEQ_ASCII;
    else if (r < 30) kind = SEQ_TWO_BYTE;
    else if (r < 50) kind = SEQ_THREE_BYTE;
    else if (r < 75) kind = SEQ_PAIR;
    else if (r < 82) kind = SEQ_BROKEN_HIGH;
    else if (r < 88) kind = SEQ_LONE_LOW;
    else if (r < 92) kind = SEQ_ZERO;
    else             kind = SEQ_RAW;
    case (kind)
      SEQ_ASCII: begin
        send_plain(16'($urandom_range(16'h0001, 16'h007F)), eon);
      end
      SEQ_TWO_BYTE: begin
        send_plain(16'($urandom_range(16'h0080, 16'h07FF)), eon);
      end
      SEQ_THREE_BYTE: begin
        cu = 16'($urandom_range(16'h0800, 16'hFFFF));
        // move surrogates up into the range F800-FFFF
        if (cu[15:11] == 5'b11011) cu = cu ^ 16'h2000;
        send_plain(cu, eon);
      end
      SEQ_PAIR: begin
        send_plain({U2U8_HIGH_TAG, 10'($urandom)}, ($urandom_range(0, 9) == 0));
        send_plain({U2U8_LOW_TAG, 10'($urandom)}, eon);
      end
      SEQ_BROKEN_HIGH: begin
        send_plain({U2U8_HIGH_TAG, 10'($urandom)}, 1'b0);
        cu = 16'($urandom);
        // anything but a low surrogate; a low turns into another high
        if (cu[15:10] == U2U8_LOW_TAG) cu[10] = 1'b0;
        send_plain(cu, eon);
      end
      SEQ_LONE_LOW: begin
        send_plain({U2U8_LOW_TAG, 10'($urandom)}, eon);
      end
      SEQ_ZERO: begin
        send_plain(16'h0000, eon);
      end
      default: begin
        send_plain(16'($urandom), eon);
      end
    endcase
  endtask

  // stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED[i]) send_unit(DIRECTED[i]);
    // long receiver hold-off while the sender keeps pushing
    hold_req <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = PHASE_SEND[ph];
      recv_stall_pct <= PHASE_RECV[ph];
      while (units_sent < NUM_DIRECTED + PHASE_END[ph]) send_random();
    end
    in_tvalid <= 1'b0;
    recv_stall_pct <= 0;
    while (utf8_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[utf16_to_utf8_transcoder] OK");
    end else begin
      $display("[utf16_to_utf8_transcoder] ERROR");
    end
    $finish;
  end

  // receiver back-pressure, with the long hold counted here
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_req   <= 1'b0;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // compare each output request against the oldest expected byte
  always @(negedge clk) begin
    utf8_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (utf8_fifo.size() == 0) begin
        $error("unexpected byte: utf8_byte=%h last_byte=%b", out_tdata, out_tlast);
        err_cnt++;
      end else begin
        exp_res = utf8_fifo.pop_front();
        if (out_tdata !== exp_res.data) begin
          $error("utf8_byte: expected %h, got %h", exp_res.data, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== exp_res.last) begin
          $error("last_byte: expected %b, got %b", exp_res.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[utf16_to_utf8_transcoder] ERROR");
      $finish;
    end
  end

endmodule
